/* rtl/efws_pkg.sv */
// Shared constants, types and state codes of the earliest-free worker scheduler.
package efws_pkg;
    localparam int MAX_WORKERS = 16;
    localparam int WIDX_W      = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
    localparam int ACT_W       = $clog2(MAX_WORKERS + 1);
    localparam int CNT_W       = 5;
    localparam int CMP_W       = (ACT_W > CNT_W) ? ACT_W : CNT_W;
    localparam int TIME_W      = 48;
    localparam int DUR_W       = 32;
    localparam int WORKER_W    = 4;
    localparam int APB_AW      = 3;
    localparam int APB_DW      = 32;
    localparam int REG_IDX_W   = APB_AW - 2;

    localparam logic [CNT_W-1:0]     WORKERS_RESET      = CNT_W'(16);
    localparam logic [REG_IDX_W-1:0] CFG_WORKERS_IN_USE = REG_IDX_W'(0);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_DONE
    } state_t;

    // running minimum handed from cell to cell
    typedef struct packed {
        logic              valid;
        logic              seed;
        logic [WIDX_W-1:0] idx;
        logic [TIME_W-1:0] free_time;
    } token_t;

    // write-back of the chosen worker's new free time
    typedef struct packed {
        logic              valid;
        logic [WIDX_W-1:0] idx;
        logic [TIME_W-1:0] free_time;
    } update_t;
endpackage

/* rtl/efws_in_if.sv */
// Job word channel: valid, ready and the job duration.
interface efws_in_if;
    import efws_pkg::*;
    logic             valid;
    logic             ready;
    logic [DUR_W-1:0] duration;

    modport source (output valid, output duration, input ready);
    modport sink   (input valid, input duration, output ready);
endinterface

/* rtl/efws_out_if.sv */
// Assignment word channel: valid, ready, worker number and start time.
interface efws_out_if;
    import efws_pkg::*;
    logic                valid;
    logic                ready;
    logic [WORKER_W-1:0] worker_number;
    logic [TIME_W-1:0]   start_time;

    modport source (output valid, output worker_number, output start_time, input ready);
    modport sink   (input valid, input worker_number, input start_time, output ready);
endinterface

/* rtl/efws_cell.sv */
// One worker cell: holds a free time and folds it into the passing minimum.
module efws_cell (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [efws_pkg::WIDX_W-1:0]   cell_idx,
    input  logic                          active,
    input  efws_pkg::token_t              tok_in,
    output efws_pkg::token_t              tok_out,
    input  efws_pkg::update_t             upd
);
    import efws_pkg::*;

    logic [TIME_W-1:0] free_time_reg;
    logic [TIME_W-1:0] free_time_next;
    token_t            tok_reg;
    token_t            tok_next;

    always_comb
    begin
        tok_next = tok_in;
        // strict less keeps the lower worker on a tie
        if (active && (tok_in.seed || (free_time_reg < tok_in.free_time)))
        begin
            tok_next.seed      = 1'b0;
            tok_next.idx       = cell_idx;
            tok_next.free_time = free_time_reg;
        end
        free_time_next = free_time_reg;
        if (upd.valid && (upd.idx == cell_idx))
        begin
            free_time_next = upd.free_time;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_time_reg <= '0;
            tok_reg       <= '0;
        end
        else
        begin
            free_time_reg <= free_time_next;
            tok_reg       <= tok_next;
        end
    end

    assign tok_out = tok_reg;
endmodule

/* rtl/efws_chain.sv */
// Row of worker cells; the minimum token walks one cell per cycle.
module efws_chain (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [efws_pkg::MAX_WORKERS-1:0]    active,
    input  efws_pkg::token_t                    tok_head,
    output efws_pkg::token_t                    tok_tail,
    input  efws_pkg::update_t                   upd
);
    import efws_pkg::*;

    token_t tok [MAX_WORKERS+1];

    assign tok[0] = tok_head;

    for (genvar k = 0; k < MAX_WORKERS; k++)
    begin : g_cell
        efws_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .cell_idx (WIDX_W'(k)),
            .active   (active[k]),
            .tok_in   (tok[k]),
            .tok_out  (tok[k+1]),
            .upd      (upd)
        );
    end

    assign tok_tail = tok[MAX_WORKERS];
endmodule

/* rtl/earliest_free_worker_scheduler_unit.sv */
// Top level of the earliest-free worker scheduler: control, config and output register.
//
//  channel   dir   word                          handshake
//  in_ch     in    duration[31:0]                valid/ready
//  out_ch    out   worker_number[3:0],           valid/ready
//                  start_time[47:0]
//  apb       in    workers_in_use @ 0x0          psel/penable/pwrite, pready=1
//
// Per job, the minimum token crosses the cell row one cell a cycle, then the
// winner is captured and written back as the output word is loaded.
// The next job is taken the cycle after the result is loaded.
// Reset clears all free times to zero and sets workers_in_use to 16.
// A stalled output holds the finished word; the write-back waits for the slot.
module earliest_free_worker_scheduler_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    efws_in_if.sink                       in_ch,
    efws_out_if.source                    out_ch,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [efws_pkg::APB_AW-1:0]   paddr,
    input  logic [efws_pkg::APB_DW-1:0]   pwdata,
    output logic [efws_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);
    import efws_pkg::*;

    state_t                state_reg;
    state_t                state_next;
    logic [CNT_W-1:0]      workers_in_use_reg;
    logic [DUR_W-1:0]      dur_reg;
    logic [WIDX_W-1:0]     win_idx_reg;
    logic [TIME_W-1:0]     win_time_reg;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [WORKER_W-1:0]   out_num_reg;
    logic [TIME_W-1:0]     out_start_reg;

    logic                  accept;
    logic                  load_out;
    logic                  cfg_write;
    logic [CMP_W-1:0]      wiu_ext;
    logic [CMP_W-1:0]      n_act;
    logic [MAX_WORKERS-1:0] active;
    logic [TIME_W:0]       sum;
    logic [TIME_W-1:0]     new_time;
    token_t                tok_head;
    token_t                tok_tail;
    update_t               upd;

    efws_chain u_chain (
        .clk      (clk),
        .rst_n    (rst_n),
        .active   (active),
        .tok_head (tok_head),
        .tok_tail (tok_tail),
        .upd      (upd)
    );

    always_comb
    begin
        wiu_ext = CMP_W'(workers_in_use_reg);
        if (wiu_ext == '0)
            n_act = CMP_W'(1);
        else if (wiu_ext > CMP_W'(MAX_WORKERS))
            n_act = CMP_W'(MAX_WORKERS);
        else
            n_act = wiu_ext;
        for (int k = 0; k < MAX_WORKERS; k++)
        begin
            active[k] = (CMP_W'(k) < n_act);
        end
    end

    always_comb
    begin
        sum      = {1'b0, win_time_reg} + (TIME_W+1)'(dur_reg);
        new_time = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
    end

    always_comb
    begin
        state_next         = state_reg;
        in_ch.ready        = (state_reg == ST_IDLE);
        accept             = in_ch.valid && in_ch.ready;
        load_out           = 1'b0;
        tok_head.valid     = accept;
        tok_head.seed      = 1'b1;
        tok_head.idx       = '0;
        tok_head.free_time = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                    state_next = ST_SEARCH;
            end
            ST_SEARCH:
            begin
                if (tok_tail.valid)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ch.ready)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        upd.valid     = load_out;
        upd.idx       = win_idx_reg;
        upd.free_time = new_time;
        if (load_out)
            out_valid_next = 1'b1;
        else if (out_ch.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign cfg_write = psel && penable && pwrite && pready
                       && (paddr[APB_AW-1:2] == CFG_WORKERS_IN_USE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_IDLE;
            out_valid_reg      <= 1'b0;
            workers_in_use_reg <= WORKERS_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_write)
                workers_in_use_reg <= pwdata[CNT_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            dur_reg <= in_ch.duration;
        if (tok_tail.valid)
        begin
            win_idx_reg  <= tok_tail.idx;
            win_time_reg <= tok_tail.free_time;
        end
        if (load_out)
        begin
            out_num_reg   <= WORKER_W'(win_idx_reg);
            out_start_reg <= win_time_reg;
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[APB_AW-1:2] == CFG_WORKERS_IN_USE)
                    ? APB_DW'(workers_in_use_reg) : '0;

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.worker_number = out_num_reg;
    assign out_ch.start_time    = out_start_reg;
endmodule

/* rtl/efws_checker.sv */
// Port-level checks of the scheduler and the bind that attaches them.
module efws_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_valid,
    input logic                           in_ready,
    input logic                           out_valid,
    input logic                           out_ready,
    input logic [efws_pkg::WORKER_W-1:0]  worker_number,
    input logic [efws_pkg::TIME_W-1:0]    start_time
);
    import efws_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(worker_number)
                                    && $stable(start_time))
        else $error("stalled output word changed");

    a_one_job: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second job taken while one is in flight");

    a_no_fast_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !$rose(out_valid))
        else $error("result appeared right after job accept");

    a_ready_on_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> in_ready)
        else $error("not ready for a job when result loaded");
endmodule

bind earliest_free_worker_scheduler_unit efws_checker u_efws_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_ch.valid),
    .in_ready      (in_ch.ready),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .worker_number (out_ch.worker_number),
    .start_time    (out_ch.start_time)
);
